/* design/pm_pkg.sv */
`default_nettype none

package pm_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = 64;
    localparam int LEN_W       = 6;
    localparam int PIDX_W      = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEN_B = CFG_IDX_W'(1);

    localparam logic REQ_LOAD_A = 1'b0;
    localparam logic REQ_LOAD_B = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* design/pm_in_if.sv */
`default_nettype none

interface pm_in_if
    import pm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [COEF_W-1:0] coef;

    modport source (output valid, output req_type, output coef, input ready);
    modport sink   (input valid, input req_type, input coef, output ready);
endinterface

`default_nettype wire

/* design/pm_out_if.sv */
`default_nettype none

interface pm_out_if
    import pm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] product_coef;
    logic [PIDX_W-1:0]        product_index;
    logic                     last;

    modport source (output valid, output product_coef, output product_index, output last,
                    input ready);
    modport sink   (input valid, input product_coef, input product_index, input last,
                    output ready);
endinterface

`default_nettype wire

/* design/polynomial_multiplier.sv */
// Channel    Dir  Payload                                   Transfer
// i_in       in   req_type, coef[31:0]                      valid & ready
// o_out      out  product_coef[63:0], product_index, last   valid & ready
// i_cfg_*    in   i_cfg_idx, i_cfg_data[5:0]                i_cfg_we
//
// Loads are accepted while ready is high; ready is high only while no product run is active.
// Run: one shared 32x32 multiplier and a 64-bit accumulator. Product k makes one
// memory read per term, then drains the read and product registers and is emitted.
// Output register holds a result until taken; a stalled sink holds up the run.
// Synchronous active-low reset clears lengths to 1 and both load counts.
`default_nettype none

module polynomial_multiplier
    import pm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pm_in_if.sink                     i_in,
    pm_out_if.source                  o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEN_W-1:0]     i_cfg_data
);

    localparam int KW = $clog2(2 * MAX_LEN);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state r_state, n_state;

    logic [LEN_W-1:0]  r_len_a, r_len_b;
    logic [KW-1:0]     r_a_cnt, r_b_cnt;
    logic [KW-1:0]     r_k, r_i;
    logic              r_v1, r_v2;
    logic signed [COEF_W-1:0] r_a_q, r_b_q;
    logic signed [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_acc;
    logic              r_out_valid;
    logic [PROD_W-1:0] r_out_coef;
    logic [PIDX_W-1:0] r_out_idx;
    logic              r_out_last;

    logic [COEF_W-1:0] r_a_mem [0:MAX_LEN-1];
    logic [COEF_W-1:0] r_b_mem [0:MAX_LEN-1];

    logic [KW-1:0] la, lb, last_k, i_hi, j_addr, k_next, i_lo_next;
    logic          in_fire, a_load, b_load, run_start, last_term, emit_fire, cfg_hit;

    always_comb begin
        if (r_len_a == '0) begin
            la = KW'(1);
        end else if (32'(r_len_a) > MAX_LEN) begin
            la = KW'(MAX_LEN);
        end else begin
            la = KW'(r_len_a);
        end
        if (r_len_b == '0) begin
            lb = KW'(1);
        end else if (32'(r_len_b) > MAX_LEN) begin
            lb = KW'(MAX_LEN);
        end else begin
            lb = KW'(r_len_b);
        end
    end

    assign last_k    = la + lb - KW'(2);
    assign i_hi      = (r_k < la - KW'(1)) ? r_k : (la - KW'(1));
    assign last_term = (r_i == i_hi);
    assign j_addr    = r_k - r_i;
    assign k_next    = r_k + KW'(1);
    assign i_lo_next = (k_next >= lb) ? (k_next - lb + KW'(1)) : '0;

    assign in_fire   = i_in.valid && (r_state == ST_IDLE);
    assign a_load    = in_fire && (i_in.req_type == REQ_LOAD_A) && (r_a_cnt < la);
    assign b_load    = in_fire && (i_in.req_type == REQ_LOAD_B) && (r_b_cnt < lb);
    assign run_start = b_load && (r_b_cnt + KW'(1) == lb);
    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign cfg_hit   = i_cfg_we && ((i_cfg_idx == REG_LEN_A) || (i_cfg_idx == REG_LEN_B));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (run_start) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (last_term) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    n_state = (r_k == last_k) ? ST_IDLE : ST_ISSUE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // config and load counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= LEN_W'(1);
            r_len_b <= LEN_W'(1);
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_LEN_A)) begin
                r_len_a <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_LEN_B)) begin
                r_len_b <= i_cfg_data;
            end
            if (cfg_hit || run_start) begin
                r_a_cnt <= '0;
                r_b_cnt <= '0;
            end else begin
                if (a_load) begin
                    r_a_cnt <= r_a_cnt + KW'(1);
                end
                if (b_load) begin
                    r_b_cnt <= r_b_cnt + KW'(1);
                end
            end
        end
    end

    // coefficient stores
    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_mem[r_a_cnt[AW-1:0]] <= i_in.coef;
        end
        if (r_state == ST_ISSUE) begin
            r_a_q <= r_a_mem[r_i[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_mem[r_b_cnt[AW-1:0]] <= i_in.coef;
        end
        if (r_state == ST_ISSUE) begin
            r_b_q <= r_b_mem[j_addr[AW-1:0]];
        end
    end

    // sequencer indices and multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_ISSUE);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_a_q) * PROD_W'(r_b_q);
        if (run_start) begin
            r_k   <= '0;
            r_i   <= '0;
            r_acc <= '0;
        end else if (r_state == ST_ISSUE) begin
            r_i <= r_i + KW'(1);
        end else if (emit_fire) begin
            r_k   <= k_next;
            r_i   <= i_lo_next;
            r_acc <= '0;
        end
        if (r_v2) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_coef <= r_acc;
            r_out_idx  <= PIDX_W'(r_k);
            r_out_last <= (r_k == last_k);
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.product_coef  = r_out_coef;
    assign o_out.product_index = r_out_idx;
    assign o_out.last          = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_cnt <= la) && (r_b_cnt <= lb))
        else $error("load count beyond length");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("product stage without read stage");

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> ((r_i <= r_k) && (r_i < la) && (j_addr < lb)))
        else $error("term index out of range");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && (r_k == last_k)) |=> (r_state == ST_IDLE) && r_out_last)
        else $error("run did not end after last product");

endmodule

`default_nettype wire
